FILE: rtl/isu_pkg.sv
package isu_pkg;

  // Default sizing of the range table.
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned ValueBits  = 32;

  // Fixed widths of the transaction fields.
  localparam int unsigned FieldW      = 32;
  localparam int unsigned CountFieldW = 5;
  localparam int unsigned StatusW     = 2;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_SHIFT
  } fsm_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_MERGE,
    OP_INSERT,
    OP_SHIFT
  } op_e;

  // Compare flags that a cell hands to its neighbors.
  typedef struct packed {
    logic below;  // entry ends before the new range starts
    logic hit;    // entry touches or overlaps the new range
  } cell_flags_t;

endpackage

FILE: rtl/isu_req_if.sv
interface isu_req_if import isu_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [FieldW-1:0] range_start;
  logic [FieldW-1:0] range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);

endinterface

FILE: rtl/isu_rsp_if.sv
interface isu_rsp_if import isu_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [StatusW-1:0]     status;
  logic [FieldW-1:0]      merged_start;
  logic [FieldW-1:0]      merged_end;
  logic [CountFieldW-1:0] entry_count;
  logic [FieldW-1:0]      lowest_start;
  logic [FieldW-1:0]      lowest_end;

  modport source (
    output valid, output status, output merged_start, output merged_end,
    output entry_count, output lowest_start, output lowest_end, input ready
  );
  modport sink (
    input valid, input status, input merged_start, input merged_end,
    input entry_count, input lowest_start, input lowest_end, output ready
  );

endinterface

FILE: rtl/isu_cell.sv
module isu_cell import isu_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  op_e                   op_i,
  input  logic                  valid_i,
  input  logic [VALUE_BITS-1:0] new_start_i,
  input  logic [VALUE_BITS-1:0] new_end_i,
  input  logic [VALUE_BITS-1:0] mrg_start_i,
  input  logic [VALUE_BITS-1:0] mrg_end_i,
  input  cell_flags_t           left_flags_i,
  input  cell_flags_t           right_flags_i,
  input  logic [VALUE_BITS-1:0] left_start_i,
  input  logic [VALUE_BITS-1:0] left_end_i,
  input  logic [VALUE_BITS-1:0] right_start_i,
  input  logic [VALUE_BITS-1:0] right_end_i,
  output cell_flags_t           flags_o,
  output logic [VALUE_BITS-1:0] start_o,
  output logic [VALUE_BITS-1:0] end_o,
  output logic [VALUE_BITS-1:0] lo_start_o,
  output logic [VALUE_BITS-1:0] last_end_o
);

  logic [VALUE_BITS-1:0] start_q, start_d;
  logic [VALUE_BITS-1:0] end_q, end_d;
  logic                  shl_q, shl_d;
  logic                  below, above, hit;
  logic                  is_lo, is_last, is_pos;

  // Compare the held entry against the new range.
  assign below   = valid_i && (end_q < new_start_i);
  assign above   = valid_i && (start_q > new_end_i);
  assign hit     = valid_i && !below && !above;
  assign is_lo   = hit && !left_flags_i.hit;
  assign is_last = hit && !right_flags_i.hit;
  assign is_pos  = !below && left_flags_i.below;

  assign flags_o.below = below;
  assign flags_o.hit   = hit;
  assign start_o       = start_q;
  assign end_o         = end_q;
  assign lo_start_o    = is_lo ? start_q : '0;
  assign last_end_o    = is_last ? end_q : '0;

  // Next entry: take the merged range, the new range, or a neighbor's entry.
  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    shl_d   = shl_q;
    case (op_i)
      OP_MERGE: begin
        if (is_lo) begin
          start_d = mrg_start_i;
          end_d   = mrg_end_i;
        end
        // Every cell past the surviving entry closes up one place per step.
        shl_d = !below && !is_lo;
      end
      OP_INSERT: begin
        if (is_pos) begin
          start_d = new_start_i;
          end_d   = new_end_i;
        end else if (!below) begin
          start_d = left_start_i;
          end_d   = left_end_i;
        end
      end
      OP_SHIFT: begin
        if (shl_q) begin
          start_d = right_start_i;
          end_d   = right_end_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shl_q <= 1'b0;
    end else begin
      shl_q <= shl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule

FILE: rtl/interval_set_union_insert.sv
// Channel | Direction | Fields
// req_i   | in        | range_start, range_end
// rsp_o   | out       | status, merged_start, merged_end, entry_count,
//         |           | lowest_start, lowest_end
//
// An item is accepted in the idle state, then compared against all cells in the
// evaluate state, which also updates the chain. Merging that absorbs k entries adds
// k - 1 shift steps, as the cell chain closes up by one place per step. A finished
// result moves to the output register in the first idle cycle in which that register
// is free, which may be the same cycle that accepts the next item.
// Reset empties the table at once; no clearing pass is needed.
// A stalled output holds its result and stops input only once a second result waits.
module interval_set_union_insert import isu_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntries,
  parameter int unsigned VALUE_BITS  = ValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  isu_req_if.sink     req_i,
  isu_rsp_if.source   rsp_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  fsm_e                  state_q, state_d;
  logic [VALUE_BITS-1:0] s_q, e_q;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       rem_q;
  logic                  pend_q;
  status_e               res_status_q;
  logic [VALUE_BITS-1:0] res_ms_q, res_me_q;

  logic                   ov_q;
  logic [StatusW-1:0]     o_status_q;
  logic [FieldW-1:0]      o_ms_q, o_me_q, o_ls_q, o_le_q;
  logic [CountFieldW-1:0] o_cnt_q;

  logic                  in_ready, accept, out_free, out_load;
  op_e                   cell_op, eval_op;
  status_e               eval_status;
  logic                  bad_range, any_hit, table_full;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [CntW-1:0]       hit_cnt, removed;
  logic [VALUE_BITS-1:0] lo_start, last_end, mrg_start, mrg_end;
  logic [VALUE_BITS-1:0] s_in, e_in;

  logic [VALUE_BITS+FieldW-1:0] s_wide, e_wide;
  logic [FieldW+VALUE_BITS-1:0] ms_wide, me_wide, ls_wide, le_wide;
  logic [CountFieldW+CntW-1:0]  cnt_wide;

  cell_flags_t           flags   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] c_start [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] c_end   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] c_lo    [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] c_last  [MAX_ENTRIES];

  // Input values fitted to the table width.
  assign s_wide = {{VALUE_BITS{1'b0}}, req_i.range_start};
  assign e_wide = {{VALUE_BITS{1'b0}}, req_i.range_end};
  assign s_in   = s_wide[VALUE_BITS-1:0];
  assign e_in   = e_wide[VALUE_BITS-1:0];

  // The chain of entry cells.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cell_flags_t           lf, rf;
    logic [VALUE_BITS-1:0] ls, le, rs, re;

    if (i == 0) begin : g_first
      assign lf = '{below: 1'b1, hit: 1'b0};
      assign ls = '0;
      assign le = '0;
    end else begin : g_mid_l
      assign lf = flags[i-1];
      assign ls = c_start[i-1];
      assign le = c_end[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign rf = '{below: 1'b0, hit: 1'b0};
      assign rs = '0;
      assign re = '0;
    end else begin : g_mid_r
      assign rf = flags[i+1];
      assign rs = c_start[i+1];
      assign re = c_end[i+1];
    end

    isu_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (cell_op),
      .valid_i       (CntW'(i) < count_q),
      .new_start_i   (s_q),
      .new_end_i     (e_q),
      .mrg_start_i   (mrg_start),
      .mrg_end_i     (mrg_end),
      .left_flags_i  (lf),
      .right_flags_i (rf),
      .left_start_i  (ls),
      .left_end_i    (le),
      .right_start_i (rs),
      .right_end_i   (re),
      .flags_o       (flags[i]),
      .start_o       (c_start[i]),
      .end_o         (c_end[i]),
      .lo_start_o    (c_lo[i]),
      .last_end_o    (c_last[i])
    );

    assign hit_vec[i] = flags[i].hit;
  end

  // Gather the first and last touched entries; at most one cell drives each.
  always_comb begin
    lo_start = '0;
    last_end = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lo_start = lo_start | c_lo[i];
      last_end = last_end | c_last[i];
    end
  end

  assign mrg_start = (lo_start < s_q) ? lo_start : s_q;
  assign mrg_end   = (last_end > e_q) ? last_end : e_q;

  // Decision for the item under evaluation.
  assign bad_range  = (e_q <= s_q);
  assign any_hit    = |hit_vec;
  assign table_full = (count_q == CntW'(MAX_ENTRIES));
  assign hit_cnt    = CntW'($countones(hit_vec));
  assign removed    = hit_cnt - CntW'(1);

  always_comb begin
    eval_op     = OP_HOLD;
    eval_status = STAT_OK;
    if (bad_range) begin
      eval_status = STAT_BAD_RANGE;
    end else if (any_hit) begin
      eval_op = OP_MERGE;
    end else if (table_full) begin
      eval_status = STAT_FULL;
    end else begin
      eval_op = OP_INSERT;
    end
  end

  // Handshake.
  assign out_free = !ov_q || rsp_o.ready;
  assign accept   = req_i.valid && in_ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        if (eval_op == OP_MERGE && removed != '0) begin
          state_d = FSM_SHIFT;
        end else begin
          state_d = FSM_IDLE;
        end
      end
      FSM_SHIFT: begin
        if (rem_q == CntW'(1)) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    cell_op  = OP_HOLD;
    case (state_q)
      FSM_IDLE: begin
        in_ready = !pend_q || out_free;
        out_load = pend_q && out_free;
      end
      FSM_EVAL: begin
        cell_op = eval_op;
      end
      FSM_SHIFT: begin
        cell_op = OP_SHIFT;
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready = in_ready;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FSM_EVAL) begin
        pend_q <= 1'b1;
        rem_q  <= removed;
        if (eval_op == OP_INSERT) begin
          count_q <= count_q + CntW'(1);
        end
      end else if (state_q == FSM_SHIFT) begin
        rem_q   <= rem_q - CntW'(1);
        count_q <= count_q - CntW'(1);
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Result field widths.
  assign ms_wide  = {{FieldW{1'b0}}, res_ms_q};
  assign me_wide  = {{FieldW{1'b0}}, res_me_q};
  assign ls_wide  = {{FieldW{1'b0}}, c_start[0]};
  assign le_wide  = {{FieldW{1'b0}}, c_end[0]};
  assign cnt_wide = {{CountFieldW{1'b0}}, count_q};

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= s_in;
      e_q <= e_in;
    end
    if (state_q == FSM_EVAL) begin
      res_status_q <= eval_status;
      res_ms_q     <= (eval_status == STAT_OK) ?
                      ((eval_op == OP_MERGE) ? mrg_start : s_q) : '0;
      res_me_q     <= (eval_status == STAT_OK) ?
                      ((eval_op == OP_MERGE) ? mrg_end : e_q) : '0;
    end
    if (out_load) begin
      o_status_q <= res_status_q;
      o_ms_q     <= ms_wide[FieldW-1:0];
      o_me_q     <= me_wide[FieldW-1:0];
      o_cnt_q    <= cnt_wide[CountFieldW-1:0];
      o_ls_q     <= (count_q != '0) ? ls_wide[FieldW-1:0] : '0;
      o_le_q     <= (count_q != '0) ? le_wide[FieldW-1:0] : '0;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = o_status_q;
  assign rsp_o.merged_start = o_ms_q;
  assign rsp_o.merged_end   = o_me_q;
  assign rsp_o.entry_count  = o_cnt_q;
  assign rsp_o.lowest_start = o_ls_q;
  assign rsp_o.lowest_end   = o_le_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import isu_pkg::*;

  // Cycles without any accepted transaction before the run is abandoned.
  localparam int unsigned QuietLimit = 2000;
  // Cycles allowed after the last result for stray output to show up.
  localparam int unsigned SettleCycles = 40;

  typedef struct packed {
    status_e                status;
    logic [FieldW-1:0]      merged_start;
    logic [FieldW-1:0]      merged_end;
    logic [CountFieldW-1:0] entry_count;
    logic [FieldW-1:0]      lowest_start;
    logic [FieldW-1:0]      lowest_end;
  } union_result_t;

  logic clk_i;
  logic rst_ni;

  isu_req_if req_if ();
  isu_rsp_if rsp_if ();

  interval_set_union_insert i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the range table, updated as each request is accepted.
  logic [FieldW-1:0] tbl_start [MaxEntries];
  logic [FieldW-1:0] tbl_end   [MaxEntries];
  int unsigned       tbl_used;

  union_result_t pending_unions[$];

  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned n_merged;
  int unsigned n_inverted;
  int unsigned n_refused;
  int unsigned quiet_cycles;

  // Both sides stop idling while this is set.
  bit          steady_flow;
  // A nonzero value asks the response side to hold off for that many cycles.
  int unsigned rsp_hold_len;

  // Unite one range with the shadow table and work out the reported fields.
  function automatic union_result_t unite_range(input logic [FieldW-1:0] s,
                                                input logic [FieldW-1:0] e);
    union_result_t r;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   gone;
    r.status       = STAT_OK;
    r.merged_start = '0;
    r.merged_end   = '0;
    if (e <= s) begin
      r.status = STAT_BAD_RANGE;
    end else begin
      // lo is the first entry reaching s, hi the first one starting past e.
      lo = 0;
      while (lo < tbl_used && tbl_end[lo] < s) lo++;
      hi = lo;
      while (hi < tbl_used && tbl_start[hi] <= e) hi++;
      if (hi > lo) begin
        gone           = hi - lo - 1;
        r.merged_start = (tbl_start[lo] < s) ? tbl_start[lo] : s;
        r.merged_end   = (tbl_end[hi-1] > e) ? tbl_end[hi-1] : e;
        tbl_start[lo]  = r.merged_start;
        tbl_end[lo]    = r.merged_end;
        for (int i = hi; i < tbl_used; i++) begin
          tbl_start[i-gone] = tbl_start[i];
          tbl_end[i-gone]   = tbl_end[i];
        end
        tbl_used -= gone;
      end else if (tbl_used >= MaxEntries) begin
        r.status = STAT_FULL;
      end else begin
        for (int i = tbl_used; i > lo; i--) begin
          tbl_start[i] = tbl_start[i-1];
          tbl_end[i]   = tbl_end[i-1];
        end
        tbl_start[lo]  = s;
        tbl_end[lo]    = e;
        r.merged_start = s;
        r.merged_end   = e;
        tbl_used++;
      end
    end
    r.entry_count  = CountFieldW'(tbl_used);
    r.lowest_start = (tbl_used > 0) ? tbl_start[0] : '0;
    r.lowest_end   = (tbl_used > 0) ? tbl_end[0] : '0;
    return r;
  endfunction

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one range and wait until the block takes it.
  task automatic push_range(input logic [FieldW-1:0] s, input logic [FieldW-1:0] e);
    @(negedge clk_i);
    if (!steady_flow && $urandom_range(99) < 9) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.range_start <= s;
    req_if.range_end   <= e;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
    end
    pending_unions.push_back(unite_range(s, e));
    items_sent++;
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_unions.size() > 0) @(posedge clk_i);
  endtask

  // Empty and inverted ranges are refused and leave the table alone.
  task automatic test_rejects();
    push_range(32'd100, 32'd100);
    push_range(32'd200, 32'd150);
  endtask

  // Plain inserts, touching neighbors, same-start widening and wide absorption.
  task automatic test_merges();
    push_range(32'd100, 32'd200);
    push_range(32'd300, 32'd400);
    push_range(32'd200, 32'd300);
    push_range(32'd100, 32'd150);
    push_range(32'd500, 32'd600);
    push_range(32'd700, 32'd800);
    push_range(32'd500, 32'd900);
    push_range(32'd50, 32'd60);
    push_range(32'd40, 32'd1000);
  endtask

  // Fill the table, get a refusal, then merge while full and collapse it.
  task automatic test_table_full();
    logic [FieldW-1:0] s;
    s = 32'd2000;
    while (tbl_used < MaxEntries) begin
      push_range(s, s + 32'd50);
      s += 32'd100;
    end
    push_range(s + 32'd1000, s + 32'd1010);
    push_range(32'd2050, 32'd2100);
    push_range(32'd10, s + 32'd500);
  endtask

  // Bursts of ranges in a moving window, each burst closed by a range that
  // folds the whole table back into one entry.
  task automatic test_random_rounds(input int unsigned n_items);
    logic [FieldW-1:0] base;
    logic [FieldW-1:0] span;
    logic [FieldW-1:0] len;
    logic [FieldW-1:0] s;
    logic [FieldW-1:0] e;
    logic [FieldW-1:0] tmp;
    int unsigned       first;
    int unsigned       burst;
    int unsigned       pick;
    int unsigned       k;
    first = items_sent;
    base  = 32'h0001_0000;
    while (items_sent - first < n_items) begin
      // The opening stretch runs without any idle cycles on either side.
      steady_flow = (items_sent - first < 300);
      span  = ($urandom_range(9) == 0) ? $urandom_range(32, 128) : $urandom_range(256, 65536);
      burst = $urandom_range(12, 30);
      repeat (burst) begin
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? 32'd1 : $urandom_range(1, span / 8 + 1);
        k    = (tbl_used > 0) ? $urandom_range(tbl_used - 1) : 0;
        if (pick < 6) begin
          // Noise: full-width values ordered so that the range is empty or inverted.
          s = $urandom;
          e = $urandom;
          if (e > s) begin
            tmp = s;
            s   = e;
            e   = tmp;
          end
        end else if (pick < 18 && tbl_used > 0) begin
          s = tbl_end[k];
          e = s + len;
        end else if (pick < 28 && tbl_used > 0 && tbl_start[k] >= len) begin
          e = tbl_start[k];
          s = e - len;
        end else if (pick < 38 && tbl_used > 0) begin
          s = tbl_start[k];
          e = s + len;
        end else begin
          s = base + $urandom_range(span);
          e = s + len;
        end
        push_range(s, e);
      end
      e = tbl_end[tbl_used-1] + $urandom_range(0, 3);
      push_range(tbl_start[0], e);
      base = e + span + $urandom_range(2, 1 << 22);
    end
    steady_flow = 1'b0;
  endtask

  // Ranges at both ends of the value space.
  task automatic test_extremes();
    push_range(32'd0, 32'd1);
    push_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_range(32'hFFFF_FFFF, 32'd0);
    push_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_range(32'd1, 32'hFFFF_FFFF);
    push_range(32'd0, 32'hFFFF_FFFF);
  endtask

  // The response side holds off for a long time while requests keep coming,
  // so the block backs up and stops taking input.
  task automatic test_output_stall();
    steady_flow  = 1'b1;
    rsp_hold_len = 300;
    repeat (24) push_range($urandom, $urandom);
    steady_flow = 1'b0;
    wait_drained();
  endtask

  // Response ready, with random idle cycles and the long hold-off on request.
  initial begin
    int unsigned hold;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_len > 0) begin
        hold         = rsp_hold_len;
        rsp_hold_len = 0;
        rsp_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      rsp_if.ready <= steady_flow || ($urandom_range(99) >= 9);
    end
  end

  task automatic check_field(input string name, input logic [FieldW-1:0] want,
                             input logic [FieldW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest outstanding union.
  always @(posedge clk_i) begin
    union_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_unions.size() == 0) begin
        $error("result transaction with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_unions.pop_front();
        check_field("status", FieldW'(want.status), FieldW'(rsp_if.status));
        check_field("merged_start", want.merged_start, rsp_if.merged_start);
        check_field("merged_end", want.merged_end, rsp_if.merged_end);
        check_field("entry_count", FieldW'(want.entry_count), FieldW'(rsp_if.entry_count));
        check_field("lowest_start", want.lowest_start, rsp_if.lowest_start);
        check_field("lowest_end", want.lowest_end, rsp_if.lowest_end);
        case (want.status)
          STAT_OK:        n_merged++;
          STAT_BAD_RANGE: n_inverted++;
          default:        n_refused++;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.range_start = '0;
    req_if.range_end   = '0;
    tbl_used           = 0;
    steady_flow        = 1'b0;
    rsp_hold_len       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_rejects();
    test_merges();
    test_table_full();
    test_random_rounds(2000);
    test_extremes();
    test_output_stall();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d ranges: %0d merged or inserted, %0d empty or inverted,",
             items_sent, n_merged, n_inverted);
    $display("%0d refused on a full table, %0d mismatches", n_refused, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/isu_pkg.sv
rtl/isu_req_if.sv
rtl/isu_rsp_if.sv
rtl/isu_cell.sv
rtl/interval_set_union_insert.sv
tb/testbench.sv
